FILE: rtl/apsp_pkg.sv
`default_nettype none

package apsp_pkg;

    // Parser phase; codes above PH_FAIL are unused
    typedef enum logic [3:0] {
        PH_MAGIC_P,
        PH_MAGIC_3,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXC,
        PH_RED,
        PH_GREEN,
        PH_BLUE,
        PH_DONE,
        PH_FAIL
    } phase_t;

    // Character codes
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Result kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 88;

    typedef struct packed {
        logic        kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] max_colour;
        logic        success;
        logic        last_result;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/ascii_ppm_stream_parser_unit.sv
`default_nettype none

// Channel  Dir  Width  Payload
// -------  ---  -----  ------------------------------------------------------
// s_axis   in   8+1    s_tdata = data_byte, s_tlast = end_of_file
// m_axis   out  88+2   m_tdata = colour / status fields, m_tuser = kind,
//                      m_tlast = last_result
//
// One byte is taken per cycle unless the held byte stalls. A byte waits
// in the input register and is parsed in a single pass into a two-entry
// result queue. The final byte of a file may give two results (pixel,
// then status); the queue holds both. A byte stalls when the queue,
// counted without a transaction leaving in the same cycle, lacks room for
// its results, so no path runs from m_tready to s_tready.
// Reset (rst_n low, asynchronous) returns the parser to waiting for 'P'.
// width*height is computed by a registered multiplier from the stored
// dimensions into prod_reg and settles there before any max colour number
// can end mid-file. Whether the image is empty is taken straight from the
// dimensions, as a one-digit max colour on the final byte may end in the
// very next cycle.
module ascii_ppm_stream_parser_unit #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // slave side
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [apsp_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic                            s_tlast,   // end_of_file
    // master side
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
    // [47:32] image_width, [63:48] image_height, [79:64] max_colour,
    // [80] success, [87:81] zero
    output logic [apsp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tuser,   // kind
    output logic                                 m_tlast    // last_result
);

    import apsp_pkg::*;

    localparam int EXT_W  = VALUE_BITS + 4;
    localparam int PROD_W = 2 * VALUE_BITS;

    // input register
    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_eof_reg;

    // parser state
    phase_t                phase_reg, phase_next;
    logic                  in_comment_reg, in_comment_next;
    logic                  in_number_reg, in_number_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [VALUE_BITS-1:0] width_reg, width_next;
    logic [VALUE_BITS-1:0] height_reg, height_next;
    logic [VALUE_BITS-1:0] maxc_reg, maxc_next;
    logic [7:0]            red_reg, red_next;
    logic [7:0]            green_reg, green_next;
    logic [31:0]           rem_reg, rem_next;
    logic [31:0]           prod_reg, prod_next;

    // result queue
    result_t               slot0_reg, slot0_next;
    result_t               slot1_reg, slot1_next;
    logic [1:0]            count_reg, count_next;

    // decode
    logic                  is_digit, is_space, is_hash;
    logic [3:0]            digit_val;
    logic [EXT_W-1:0]      acc_ext, acc_sum;
    logic [VALUE_BITS-1:0] acc_digit;
    logic                  active, parse_body;
    logic                  path_comment, path_magic3, path_acc, path_sep;
    logic                  fin_take, fin_eof, fin_start, do_finish;
    logic [VALUE_BITS-1:0] fin_value;
    phase_t                fin_phase, sep_phase;
    logic                  sep_active, pixel_emit;

    // status snapshot (before the end-of-file reset)
    logic [VALUE_BITS-1:0] stat_width, stat_height, stat_maxc;
    logic                  stat_ok;

    logic [PROD_W-1:0]     prod_full;
    result_t               res0, res1;
    logic [1:0]            n_res;
    logic                  proc, s_accept, pop;
    logic [1:0]            base;

    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;

    assign n_res = 2'(pixel_emit) + 2'(in_eof_reg);
    assign proc  = in_valid_reg && ((3'(count_reg) + 3'(n_res)) <= 3'd2);
    assign s_tready = !in_valid_reg || proc;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end
    end

    // dimension product, saturated to 32 bits
    assign prod_full = PROD_W'(width_reg) * PROD_W'(height_reg);

    generate
        if (PROD_W > 32)
        begin : g_prod_sat
            assign prod_next = (|prod_full[PROD_W-1:32]) ? '1 : prod_full[31:0];
        end
        else
        begin : g_prod_fit
            assign prod_next = 32'(prod_full);
        end
    endgenerate

    // byte decode and path selection
    always_comb
    begin
        is_digit  = (in_byte_reg >= CH_0) && (in_byte_reg <= CH_9);
        is_space  = (in_byte_reg == CH_SPACE) || (in_byte_reg == CH_TAB)
                 || (in_byte_reg == CH_CR) || (in_byte_reg == CH_LF);
        is_hash   = (in_byte_reg == CH_HASH);
        digit_val = 4'(in_byte_reg - CH_0);

        // acc*10 + digit, saturating
        acc_ext   = EXT_W'(acc_reg);
        acc_sum   = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(digit_val);
        acc_digit = (|acc_sum[EXT_W-1:VALUE_BITS]) ? '1 : acc_sum[VALUE_BITS-1:0];

        active       = (phase_reg != PH_DONE) && (phase_reg != PH_FAIL);
        path_comment = active && in_comment_reg;
        parse_body   = active && !in_comment_reg && (phase_reg != PH_MAGIC_3);
        path_magic3  = active && !in_comment_reg && (phase_reg == PH_MAGIC_3);
        path_acc     = parse_body && in_number_reg && is_digit;
        fin_take     = parse_body && in_number_reg && !is_digit;
        path_sep     = parse_body && !in_number_reg;
        fin_eof      = in_eof_reg && path_acc;
        // a number begun by the final byte is ended by it as well
        fin_start    = in_eof_reg && path_sep && is_digit && (phase_reg != PH_MAGIC_P);
        do_finish    = fin_take || fin_eof || fin_start;
        fin_value    = fin_take ? acc_reg : (fin_eof ? acc_digit : VALUE_BITS'(digit_val));

        unique case (phase_reg)
            PH_WIDTH:  fin_phase = PH_HEIGHT;
            PH_HEIGHT: fin_phase = PH_MAXC;
            PH_MAXC:   fin_phase = ((width_reg == '0) || (height_reg == '0)) ? PH_DONE : PH_RED;
            PH_RED:    fin_phase = PH_GREEN;
            PH_GREEN:  fin_phase = PH_BLUE;
            PH_BLUE:   fin_phase = (rem_reg <= 32'd1) ? PH_DONE : PH_RED;
            default:   fin_phase = phase_reg;
        endcase

        pixel_emit = do_finish && (phase_reg == PH_BLUE);
        sep_active = path_sep || (fin_take && (fin_phase != PH_DONE));
        sep_phase  = path_sep ? phase_reg : fin_phase;
    end

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        in_comment_next = in_comment_reg;
        in_number_next  = in_number_reg;
        acc_next        = acc_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        maxc_next       = maxc_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        rem_next        = rem_reg;

        if (path_comment && (in_byte_reg == CH_LF))
        begin
            in_comment_next = 1'b0;
        end

        if (path_magic3)
        begin
            if (in_byte_reg == CH_3)
            begin
                phase_next = PH_WIDTH;
            end
            else
            begin
                phase_next = PH_FAIL;
            end
        end

        if (path_acc)
        begin
            acc_next = acc_digit;
        end

        if (do_finish)
        begin
            in_number_next = 1'b0;
            phase_next     = fin_phase;
            unique case (phase_reg)
                PH_WIDTH:  width_next  = fin_value;
                PH_HEIGHT: height_next = fin_value;
                PH_MAXC:
                begin
                    maxc_next = fin_value;
                    rem_next  = prod_reg;
                end
                PH_RED:    red_next   = fin_value[7:0];
                PH_GREEN:  green_next = fin_value[7:0];
                PH_BLUE:   rem_next   = (rem_reg == 32'd0) ? 32'd0 : rem_reg - 32'd1;
                default:   ;
            endcase
        end

        // separator / token start
        if (sep_active)
        begin
            priority if (is_space)
            begin
                phase_next = sep_phase;
            end
            else if (is_hash)
            begin
                in_comment_next = 1'b1;
            end
            else if (sep_phase == PH_MAGIC_P)
            begin
                phase_next = (in_byte_reg == CH_P) ? PH_MAGIC_3 : PH_FAIL;
            end
            else if (is_digit)
            begin
                in_number_next = 1'b1;
                acc_next       = VALUE_BITS'(digit_val);
            end
            else
            begin
                phase_next = PH_FAIL;
            end
        end

        if (phase_next == PH_FAIL)
        begin
            in_number_next  = 1'b0;
            in_comment_next = 1'b0;
        end

        stat_width  = width_next;
        stat_height = height_next;
        stat_maxc   = maxc_next;
        stat_ok     = (phase_next == PH_DONE);

        // end of file: back to start
        if (in_eof_reg)
        begin
            phase_next      = PH_MAGIC_P;
            in_comment_next = 1'b0;
            in_number_next  = 1'b0;
            acc_next        = '0;
            width_next      = '0;
            height_next     = '0;
            maxc_next       = '0;
            red_next        = 8'd0;
            green_next      = 8'd0;
            rem_next        = 32'd0;
        end
    end

    // result build
    always_comb
    begin
        result_t pix;
        result_t stat;

        pix              = '0;
        pix.kind         = KIND_PIXEL;
        pix.red          = red_reg;
        pix.green        = green_reg;
        pix.blue         = fin_value[7:0];
        pix.alpha        = ALPHA_OPAQUE;
        pix.last_result  = !in_eof_reg;

        stat              = '0;
        stat.kind         = KIND_STATUS;
        stat.image_width  = 16'(stat_width);
        stat.image_height = 16'(stat_height);
        stat.max_colour   = 16'(stat_maxc);
        stat.success      = stat_ok;
        stat.last_result  = 1'b1;

        res0 = pixel_emit ? pix : stat;
        res1 = stat;
    end

    // result queue: pop from slot0, push at the first free slot
    always_comb
    begin
        base       = count_reg - 2'(pop);
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        count_next = base;
        if (proc)
        begin
            count_next = base + n_res;
        end
        // a byte with no result leaves the queued ones alone
        if (proc && (n_res != 2'd0))
        begin
            if (base == 2'd0)
            begin
                slot0_next = res0;
                slot1_next = res1;
            end
            else
            begin
                slot1_next = res0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            count_reg      <= 2'd0;
            phase_reg      <= PH_MAGIC_P;
            in_comment_reg <= 1'b0;
            in_number_reg  <= 1'b0;
            acc_reg        <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            maxc_reg       <= '0;
            red_reg        <= 8'd0;
            green_reg      <= 8'd0;
            rem_reg        <= 32'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            count_reg    <= count_next;
            if (proc)
            begin
                phase_reg      <= phase_next;
                in_comment_reg <= in_comment_next;
                in_number_reg  <= in_number_next;
                acc_reg        <= acc_next;
                width_reg      <= width_next;
                height_reg     <= height_next;
                maxc_reg       <= maxc_next;
                red_reg        <= red_next;
                green_reg      <= green_next;
                rem_reg        <= rem_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_eof_reg  <= s_tlast;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
        prod_reg  <= prod_next;
    end

    assign m_tdata = {7'd0, slot0_reg.success, slot0_reg.max_colour,
                      slot0_reg.image_height, slot0_reg.image_width,
                      slot0_reg.alpha, slot0_reg.blue, slot0_reg.green,
                      slot0_reg.red};
    assign m_tuser = slot0_reg.kind;
    assign m_tlast = slot0_reg.last_result;

    // ---------------------------------------------------------------- checks

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue overfilled");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_STATUS)) |-> m_tlast)
        else $error("status transaction without last flag");

    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_eof_reg) |=> (phase_reg == PH_MAGIC_P) && !in_number_reg)
        else $error("parser not restarted after final byte");

    a_pixels_left: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_RED) || (phase_reg == PH_GREEN) || (phase_reg == PH_BLUE))
        |-> (rem_reg != 32'd0))
        else $error("pixel phase with no pixels remaining");

endmodule

`default_nettype wire

FILE: verif/ascii_ppm_stream_parser_unit_test.sv
`default_nettype none

// Bytes of ASCII P3 images go in on the slave side, one per transaction, with
// s_tlast on the final byte of each file. A parser model inside this module
// follows every accepted byte and queues the pixel and status results that
// the byte must produce. Each result transaction on the master side is then
// checked field by field against the oldest queued result.
module ascii_ppm_stream_parser_unit_test;

    import apsp_pkg::*;

    localparam int          VB           = 16;
    localparam logic [63:0] VALUE_MAX    = (64'd1 << VB) - 64'd1;
    localparam int          QUIET_LIMIT  = 1000;  // cycles with no transaction at all
    localparam int          DRAIN_CYCLES = 20;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // When set, neither side idles: used for the closing part of the run
    bit          calm         = 1'b0;
    int unsigned errors       = 0;
    int unsigned sent_bytes   = 0;
    int unsigned results_seen = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sink_hold    = 0;

    // Results still owed by the block, oldest first
    result_t     due_results[$];
    // Text of the file being built
    logic [7:0]  file_text[$];

    // Parser model state
    phase_t      parse_at;
    bit          in_cmt;
    bit          in_num;
    logic [63:0] num_acc;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [31:0] img_max;
    logic [7:0]  red_v;
    logic [7:0]  green_v;
    logic [31:0] pixels_left;
    bit          parse_failed;

    ascii_ppm_stream_parser_unit #(
        .VALUE_BITS (VB)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    task automatic reset_parser();
        parse_at     = PH_MAGIC_P;
        in_cmt       = 1'b0;
        in_num       = 1'b0;
        num_acc      = '0;
        img_w        = '0;
        img_h        = '0;
        img_max      = '0;
        red_v        = '0;
        green_v      = '0;
        pixels_left  = '0;
        parse_failed = 1'b0;
    endtask

    task automatic fail_parse();
        parse_at     = PH_FAIL;
        parse_failed = 1'b1;
        in_num       = 1'b0;
        in_cmt       = 1'b0;
    endtask

    // Closes the number in progress; a blue value completes a pixel
    task automatic end_number(output bit emitted, output result_t px);
        logic [31:0] v;
        logic [63:0] area;
        v       = num_acc[31:0];
        in_num  = 1'b0;
        emitted = 1'b0;
        px      = '0;
        case (parse_at)
            PH_WIDTH:
            begin
                img_w    = v;
                parse_at = PH_HEIGHT;
            end
            PH_HEIGHT:
            begin
                img_h    = v;
                parse_at = PH_MAXC;
            end
            PH_MAXC:
            begin
                area        = {32'd0, img_w} * {32'd0, img_h};
                img_max     = v;
                pixels_left = (area > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : area[31:0];
                parse_at    = (pixels_left == 0) ? PH_DONE : PH_RED;
            end
            PH_RED:
            begin
                red_v    = v[7:0];
                parse_at = PH_GREEN;
            end
            PH_GREEN:
            begin
                green_v  = v[7:0];
                parse_at = PH_BLUE;
            end
            PH_BLUE:
            begin
                px.kind        = KIND_PIXEL;
                px.red         = red_v;
                px.green       = green_v;
                px.blue        = v[7:0];
                px.alpha       = ALPHA_OPAQUE;
                px.last_result = 1'b1;
                emitted        = 1'b1;
                if (pixels_left != 0)
                    pixels_left = pixels_left - 1;
                parse_at = (pixels_left == 0) ? PH_DONE : PH_RED;
            end
            default: ;
        endcase
    endtask

    task automatic consume_byte(input logic [7:0] c, output bit got_px, output result_t px);
        logic [63:0] grown;
        got_px = 1'b0;
        px     = '0;
        if (parse_at == PH_FAIL || parse_at == PH_DONE)
            return;
        if (in_cmt)
        begin
            if (c == CH_LF)
                in_cmt = 1'b0;
            return;
        end
        // second byte of the magic: only '3' will do
        if (parse_at == PH_MAGIC_3)
        begin
            if (c == CH_3)
                parse_at = PH_WIDTH;
            else
                fail_parse();
            return;
        end
        if (in_num)
        begin
            if (c >= CH_0 && c <= CH_9)
            begin
                grown   = num_acc * 64'd10 + {56'd0, c - CH_0};
                num_acc = (grown > VALUE_MAX) ? VALUE_MAX : grown;
                return;
            end
            // the byte that ends a number is still a separator, unless the
            // image has just been completed
            end_number(got_px, px);
            if (parse_at == PH_DONE)
                return;
        end
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)
            return;
        if (c == CH_HASH)
        begin
            in_cmt = 1'b1;
            return;
        end
        if (parse_at == PH_MAGIC_P)
        begin
            if (c == CH_P)
                parse_at = PH_MAGIC_3;
            else
                fail_parse();
            return;
        end
        if (c >= CH_0 && c <= CH_9)
        begin
            in_num  = 1'b1;
            num_acc = {56'd0, c - CH_0};
        end
        else
            fail_parse();
    endtask

    // Queues what one accepted byte must produce
    task automatic predict_byte(input logic [7:0] c, input logic eof);
        bit      got_px;
        result_t px;
        result_t st;
        consume_byte(c, got_px, px);
        if (!eof)
        begin
            if (got_px)
                due_results.push_back(px);
            return;
        end
        // final byte: flush a pending number, then the status result
        if (in_num && !got_px)
            end_number(got_px, px);
        if (got_px)
        begin
            px.last_result = 1'b0;
            due_results.push_back(px);
        end
        st              = '0;
        st.kind         = KIND_STATUS;
        st.image_width  = img_w[15:0];
        st.image_height = img_h[15:0];
        st.max_colour   = img_max[15:0];
        st.success      = (parse_at == PH_DONE) && !parse_failed;
        st.last_result  = 1'b1;
        due_results.push_back(st);
        reset_parser();
    endtask

    // ------------------------------------------------------------------
    // Slave side
    // ------------------------------------------------------------------

    // One byte transaction; tvalid is only dropped for an idle burst
    task automatic send_byte(input logic [7:0] b, input logic eof);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        do
            @(posedge clk);
        while (!s_tready);
        predict_byte(b, eof);
        sent_bytes++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_text.size(); i++)
            send_byte(file_text[i], i == file_text.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // File text builders
    // ------------------------------------------------------------------

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            file_text.push_back(s[i]);
    endtask

    task automatic add_number(input int unsigned v);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) file_text.push_back(CH_0);
        add_text($sformatf("%0d", v));
    endtask

    // White space and comments; comment bodies carry arbitrary bytes other than LF
    task automatic add_gap();
        logic [7:0] b;
        repeat ($urandom_range(1, 2))
        begin
            case ($urandom_range(0, 5))
                0, 1: file_text.push_back(CH_SPACE);
                2:    file_text.push_back(CH_TAB);
                3:    file_text.push_back(CH_CR);
                4:    file_text.push_back(CH_LF);
                default:
                begin
                    file_text.push_back(CH_HASH);
                    repeat ($urandom_range(0, 6))
                    begin
                        b = 8'($urandom_range(0, 255));
                        file_text.push_back((b == CH_LF) ? CH_SPACE : b);
                    end
                    file_text.push_back(CH_LF);
                end
            endcase
        end
    endtask

    // A well-formed image of at most 3x3 pixels, or an empty one with one very large dimension, with random layout
    task automatic build_image();
        int unsigned cols;
        int unsigned rows;
        int unsigned maxc;
        file_text.delete();
        if ($urandom_range(0, 3) == 0)
            add_gap();
        add_text("P3");
        if ($urandom_range(0, 5) != 0)
            add_gap();
        cols = $urandom_range(0, 3);
        rows = $urandom_range(0, 3);
        // now and then an empty image with one very large dimension
        if ($urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                cols = $urandom_range(0, 1) ? 65535 : 123456;
                rows = 0;
            end
            else
            begin
                rows = $urandom_range(0, 1) ? 65535 : 123456;
                cols = 0;
            end
        end
        case ($urandom_range(0, 2))
            0:       maxc = 255;
            1:       maxc = 65535;
            default: maxc = $urandom_range(0, 99999);
        endcase
        add_number(cols);
        add_gap();
        add_number(rows);
        add_gap();
        add_number(maxc);
        repeat (cols * rows * 3)
        begin
            add_gap();
            if ($urandom_range(0, 4) != 0)
                add_number($urandom_range(0, 255));
            else
                add_number($urandom_range(0, 9999999));
        end
        // tail: end on the last digit, white space, or ignored junk
        case ($urandom_range(0, 3))
            0: ;
            1: add_gap();
            2: repeat ($urandom_range(1, 4)) file_text.push_back(8'($urandom_range(0, 255)));
            default:
            begin
                add_gap();
                repeat ($urandom_range(1, 4)) file_text.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_files();
        // width follows the magic with no gap; empty image succeeds
        file_text.delete();
        add_text("P30 7 9");
        send_file();
        // saturated max colour, red truncated to 8 bits, pixel and status
        // both produced by the final byte
        file_text.delete();
        add_text("P3 1 1 99999 256 2 3");
        send_file();
        // bad magic
        file_text.delete();
        add_text("P4");
        send_file();
        // stray byte before the magic
        file_text.delete();
        add_text("x");
        send_file();
    endtask

    task automatic test_wellformed_images();
        int unsigned start;
        start = sent_bytes;
        while (sent_bytes - start < 750)
        begin
            build_image();
            send_file();
        end
    endtask

    // Truncated, corrupted and noise files
    task automatic test_broken_files();
        int unsigned start;
        int unsigned keep;
        start = sent_bytes;
        while (sent_bytes - start < 350)
        begin
            build_image();
            case ($urandom_range(0, 3))
                0:
                begin
                    keep = $urandom_range(1, file_text.size());
                    while (file_text.size() > keep)
                        file_text.delete(file_text.size() - 1);
                end
                1: file_text[$urandom_range(0, file_text.size() - 1)] = 8'($urandom_range(0, 255));
                2: file_text.push_front(8'($urandom_range(0, 255)));
                default:
                begin
                    file_text.delete();
                    repeat ($urandom_range(1, 6)) file_text.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            send_file();
        end
    endtask

    // Back-to-back transactions on both sides
    task automatic test_steady_stream();
        int unsigned start;
        calm  = 1'b1;
        start = sent_bytes;
        while (sent_bytes - start < 220)
        begin
            build_image();
            send_file();
        end
    endtask

    initial
    begin
        reset_parser();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_files();
        test_wellformed_images();
        test_broken_files();
        test_steady_stream();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Master side
    // ------------------------------------------------------------------

    // Sink drops m_tready in random bursts, except while calm
    always @(posedge clk)
    begin
        if (sink_hold != 0)
        begin
            sink_hold <= sink_hold - 1;
            m_tready  <= (sink_hold == 1);
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            sink_hold <= $urandom_range(1, 4);
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s got %0h want %0h", results_seen, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_results.size() == 0)
                report_mismatch("transaction with no result due", 32'(m_tuser), 32'd0);
            else
            begin
                want = due_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[7:0] !== want.red)
                    report_mismatch("red", 32'(m_tdata[7:0]), 32'(want.red));
                if (m_tdata[15:8] !== want.green)
                    report_mismatch("green", 32'(m_tdata[15:8]), 32'(want.green));
                if (m_tdata[23:16] !== want.blue)
                    report_mismatch("blue", 32'(m_tdata[23:16]), 32'(want.blue));
                if (m_tdata[31:24] !== want.alpha)
                    report_mismatch("alpha", 32'(m_tdata[31:24]), 32'(want.alpha));
                if (m_tdata[47:32] !== want.image_width)
                    report_mismatch("image_width", 32'(m_tdata[47:32]),
                                    32'(want.image_width));
                if (m_tdata[63:48] !== want.image_height)
                    report_mismatch("image_height", 32'(m_tdata[63:48]),
                                    32'(want.image_height));
                if (m_tdata[79:64] !== want.max_colour)
                    report_mismatch("max_colour", 32'(m_tdata[79:64]),
                                    32'(want.max_colour));
                if (m_tdata[80] !== want.success)
                    report_mismatch("success", 32'(m_tdata[80]), 32'(want.success));
                if (m_tdata[87:81] !== 7'd0)
                    report_mismatch("padding", 32'(m_tdata[87:81]), 32'd0);
                if (m_tlast !== want.last_result)
                    report_mismatch("last_result", 32'(m_tlast), 32'(want.last_result));
            end
            results_seen++;
        end
    end

    // Watchdog: a run with no transaction on either side for too long is hung
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/apsp_pkg.sv
rtl/ascii_ppm_stream_parser_unit.sv
verif/ascii_ppm_stream_parser_unit_test.sv
